// ===== rtl/ckcr_pkg.sv =====
// Package for the chroma key color replace block: widths, register codes,
// CORDIC arctangent table. No dependencies.
package ckcr_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int PIX_W          = 16;   // pixel field width
    localparam int REG_W          = 13;   // key/target register width
    localparam int TOL_W          = 9;    // tolerance register width
    localparam int CFG_IDX_W      = 3;
    localparam int QUO_W          = 13;   // quotient bits of both dividers
    localparam int ANG_W          = 32;   // angle accumulator, 2^32 = full turn
    localparam int CORDIC_W       = 31;   // CORDIC x/y datapath width
    localparam int WEIGHT_ONE     = 4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_CB      = 3'd0,
        CFG_KEY_CR      = 3'd1,
        CFG_KEY_LUMA    = 3'd2,
        CFG_TARGET_CB   = 3'd3,
        CFG_TARGET_CR   = 3'd4,
        CFG_TARGET_LUMA = 3'd5,
        CFG_HUE_TOL     = 3'd6,
        CFG_SAT_TOL     = 3'd7
    } t_cfg_reg;

    // atan(2^-i) in units where 2^32 is a full turn
    function automatic logic [ANG_W-1:0] atan_turn(input int idx);
        logic [ANG_W-1:0] v;
        begin
            case (idx)
                0:  v = 32'd536870912;
                1:  v = 32'd316933406;
                2:  v = 32'd167458907;
                3:  v = 32'd85004756;
                4:  v = 32'd42667331;
                5:  v = 32'd21354465;
                6:  v = 32'd10679838;
                7:  v = 32'd5340245;
                8:  v = 32'd2670163;
                9:  v = 32'd1335087;
                10: v = 32'd667544;
                11: v = 32'd333772;
                12: v = 32'd166886;
                13: v = 32'd83443;
                14: v = 32'd41722;
                15: v = 32'd20861;
                16: v = 32'd10430;
                17: v = 32'd5215;
                18: v = 32'd2608;
                19: v = 32'd1304;
                20: v = 32'd652;
                21: v = 32'd326;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== rtl/ckcr_if.sv =====
// Channel interfaces: input pixel, output pixel, configuration write.
// Depends on ckcr_pkg.
interface ckcr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ckcr_pkg::PIX_W-1:0]   in_luma;
    logic signed [ckcr_pkg::PIX_W-1:0]   in_cb;
    logic signed [ckcr_pkg::PIX_W-1:0]   in_cr;
    modport source (output valid, in_luma, in_cb, in_cr, input ready);
    modport sink   (input valid, in_luma, in_cb, in_cr, output ready);
endinterface

interface ckcr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ckcr_pkg::PIX_W-1:0]   out_luma;
    logic signed [ckcr_pkg::PIX_W-1:0]   out_cb;
    logic signed [ckcr_pkg::PIX_W-1:0]   out_cr;
    modport source (output valid, out_luma, out_cb, out_cr, input ready);
    modport sink   (input valid, out_luma, out_cb, out_cr, output ready);
endinterface

interface ckcr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ckcr_pkg::CFG_IDX_W-1:0]      index;
    logic [ckcr_pkg::REG_W-1:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ckcr_delay.sv =====
// Enabled shift line that aligns pipeline branches of unequal latency.
// No dependencies.
module ckcr_delay #(
    parameter int W   = 8,
    parameter int LEN = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);
    generate
        if (LEN == 0) begin : g_none
            assign o_d = i_d;
        end else begin : g_line
            logic [W-1:0] r_sh [0:LEN-1];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sh[0] <= i_d;
                end
            end
            for (genvar k = 1; k < LEN; k++) begin : g_tap
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_sh[k] <= r_sh[k-1];
                    end
                end
            end
            assign o_d = r_sh[LEN-1];
        end
    endgenerate
endmodule

// ===== rtl/ckcr_cordic.sv =====
// Pipelined vectoring CORDIC: angle of (x, y), one iteration per stage.
// Depends on ckcr_pkg (widths, arctangent table).
module ckcr_cordic #(
    parameter int ITER = ckcr_pkg::ANGLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [ckcr_pkg::PIX_W-1:0]   i_x,
    input  logic signed [ckcr_pkg::PIX_W-1:0]   i_y,
    output logic [ckcr_pkg::ANG_W-1:0]          o_angle
);
    localparam int AW    = ckcr_pkg::CORDIC_W;
    localparam int ZW    = ckcr_pkg::ANG_W;
    localparam int SHIFT = ZW - ITER;
    localparam logic [ZW-1:0] HALF = ZW'(1) << (SHIFT - 1);
    localparam logic [ZW-1:0] KEEP = ~((ZW'(1) << SHIFT) - ZW'(1));

    logic signed [AW-1:0] r_a    [0:ITER-1];
    logic signed [AW-1:0] r_b    [0:ITER-1];
    logic [ZW-1:0]        r_z    [0:ITER];
    logic                 r_zero [0:ITER];
    logic [ZW-1:0]        r_angle;

    logic signed [AW-1:0] n_a, n_b;
    logic [ZW-1:0]        n_z;

    // scale by 4096; left half plane turned by a half turn
    always_comb begin
        n_a = {{(AW-ckcr_pkg::PIX_W-12){i_x[ckcr_pkg::PIX_W-1]}}, i_x, 12'd0};
        n_b = {{(AW-ckcr_pkg::PIX_W-12){i_y[ckcr_pkg::PIX_W-1]}}, i_y, 12'd0};
        n_z = '0;
        if (i_x[ckcr_pkg::PIX_W-1]) begin
            n_a = -n_a;
            n_b = -n_b;
            n_z = {1'b1, {(ZW-1){1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a[0]    <= n_a;
            r_b[0]    <= n_b;
            r_z[0]    <= n_z;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
        end
    end

    // one micro-rotation per stage, driving y toward zero
    for (genvar i = 0; i < ITER; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (!r_b[i][AW-1]) begin
                    r_z[i+1] <= r_z[i] + ckcr_pkg::atan_turn(i);
                end else begin
                    r_z[i+1] <= r_z[i] - ckcr_pkg::atan_turn(i);
                end
            end
        end

        // the last iteration only needs the direction, not the new x/y
        if (i < ITER - 1) begin : g_xy
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!r_b[i][AW-1]) begin
                        r_a[i+1] <= r_a[i] + (r_b[i] >>> i);
                        r_b[i+1] <= r_b[i] - (r_a[i] >>> i);
                    end else begin
                        r_a[i+1] <= r_a[i] - (r_b[i] >>> i);
                        r_b[i+1] <= r_b[i] + (r_a[i] >>> i);
                    end
                end
            end
        end
    end

    // round half up to ITER bits of a turn
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= r_zero[ITER] ? '0 : ((r_z[ITER] + HALF) & KEEP);
        end
    end

    assign o_angle = r_angle;
endmodule

// ===== rtl/ckcr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit QW bits for a valid result. No dependencies.
module ckcr_div #(
    parameter int NUM_W = 28,
    parameter int DIV_W = 13,
    parameter int QW    = 13
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    output logic [QW-1:0]    o_quo
);
    localparam int RW = DIV_W + 1;

    logic [RW-1:0] p_rem [0:QW-1];
    logic [QW-1:0] p_num [0:QW-1];
    logic [QW-1:0] p_quo [0:QW-1];
    logic [RW-1:0] r_rem [1:QW-1];
    logic [QW-1:0] r_num [1:QW-1];
    logic [QW-1:0] r_quo [1:QW];

    // upper numerator bits seed the partial remainder
    assign p_rem[0] = RW'(i_num >> QW);
    assign p_num[0] = i_num[QW-1:0];
    assign p_quo[0] = '0;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [RW-1:0] trial;
        logic          ge;

        if (k > 0) begin : g_link
            assign p_rem[k] = r_rem[k];
            assign p_num[k] = r_num[k];
            assign p_quo[k] = r_quo[k];
        end

        assign trial = {p_rem[k][RW-2:0], p_num[k][QW-1-k]};
        assign ge    = trial >= {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k+1] <= {p_quo[k][QW-2:0], ge};
            end
        end

        // remainder and numerator bits only travel on to a later stage
        if (k < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= ge ? (trial - {1'b0, i_den}) : trial;
                    r_num[k+1] <= p_num[k];
                end
            end
        end
    end

    assign o_quo = r_quo[QW];
endmodule

// ===== rtl/chroma_key_color_replace.sv =====
// Top level of the chroma key color replace block.
// Depends on ckcr_pkg, ckcr_if, ckcr_delay, ckcr_cordic, ckcr_div.
//
//  port     | direction | moves
//  ---------+-----------+-------------------------------------------
//  i_pix    | sink      | pixel item: in_luma, in_cb, in_cr
//  o_pix    | source    | result item: out_luma, out_cb, out_cr
//  i_cfg    | sink      | register write: index, data (always ready)
//
// One item per clock while o_pix is not stalled. Delay lines align every branch
// to the slower of the CORDIC angle pipeline (one iteration per stage) and
// the 13-stage quotient pipelines.
// Reset clears the configuration registers and valid bits, not the data registers; no clearing pass.
// Stages advance whenever the output register loads or the stage before it
// is empty, so a bubble there closes up behind a stalled result; nothing is dropped.
module chroma_key_color_replace #(
    parameter int ANGLE_BITS = ckcr_pkg::ANGLE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ckcr_in_if.sink        i_pix,
    ckcr_out_if.source     o_pix,
    ckcr_cfg_if.sink       i_cfg
);
    localparam int PW      = ckcr_pkg::PIX_W;
    localparam int RW      = ckcr_pkg::REG_W;
    localparam int TW      = ckcr_pkg::TOL_W;
    localparam int QW      = ckcr_pkg::QUO_W;
    localparam int ZW      = ckcr_pkg::ANG_W;
    localparam int LAT_COR = ANGLE_BITS + 2;
    localparam int LAT_DIV = 2 + QW;
    localparam int JOIN    = (LAT_COR > LAT_DIV) ? LAT_COR : LAT_DIV;
    localparam int LAST    = JOIN + 4;
    localparam int BUS_W   = 3 * PW + PW + (PW - 1) + 2;

    // ---------------- configuration registers ----------------
    logic signed [RW-1:0] r_key_cb, r_key_cr, r_target_cb, r_target_cr;
    logic [RW-1:0]        r_key_luma, r_target_luma;
    logic [TW-1:0]        r_hue_tol, r_sat_tol;
    logic [RW-1:0]        r_keysat;
    logic [RW:0]          r_sat_range;
    logic [RW-1:0]        abs_kcb, abs_kcr, n_keysat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_cb      <= '0;
            r_key_cr      <= '0;
            r_key_luma    <= '0;
            r_target_cb   <= '0;
            r_target_cr   <= '0;
            r_target_luma <= '0;
            r_hue_tol     <= '0;
            r_sat_tol     <= '0;
        end else if (i_cfg.valid) begin
            unique case (ckcr_pkg::t_cfg_reg'(i_cfg.index))
                ckcr_pkg::CFG_KEY_CB:      r_key_cb      <= i_cfg.data;
                ckcr_pkg::CFG_KEY_CR:      r_key_cr      <= i_cfg.data;
                ckcr_pkg::CFG_KEY_LUMA:    r_key_luma    <= i_cfg.data;
                ckcr_pkg::CFG_TARGET_CB:   r_target_cb   <= i_cfg.data;
                ckcr_pkg::CFG_TARGET_CR:   r_target_cr   <= i_cfg.data;
                ckcr_pkg::CFG_TARGET_LUMA: r_target_luma <= i_cfg.data;
                ckcr_pkg::CFG_HUE_TOL:     r_hue_tol     <= i_cfg.data[TW-1:0];
                ckcr_pkg::CFG_SAT_TOL:     r_sat_tol     <= i_cfg.data[TW-1:0];
                default: ;
            endcase
        end
    end

    // key saturation and saturation range, derived from the registers
    always_comb begin
        abs_kcb  = r_key_cb[RW-1] ? RW'(-r_key_cb) : r_key_cb;
        abs_kcr  = r_key_cr[RW-1] ? RW'(-r_key_cr) : r_key_cr;
        n_keysat = (abs_kcb > abs_kcr) ? abs_kcb : abs_kcr;
        if (n_keysat == '0) begin
            n_keysat = RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keysat    <= RW'(1);
            r_sat_range <= '0;
        end else begin
            r_keysat    <= n_keysat;
            r_sat_range <= (RW+1)'(((TW+RW)'(r_sat_tol) * (TW+RW)'(n_keysat)) >> 8);
        end
    end

    // ---------------- flow control ----------------
    logic r_vld [1:LAST];
    logic en, out_load;

    assign out_load    = !r_vld[LAST] || o_pix.ready;
    assign en          = out_load || !r_vld[LAST-1];
    assign i_pix.ready = en;
    assign o_pix.valid = r_vld[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (en) begin
                r_vld[1] <= i_pix.valid;
                for (int k = 2; k < LAST; k++) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (out_load) begin
                r_vld[LAST] <= r_vld[LAST-1];
            end
        end
    end

    // ---------------- stage 1: saturation, clamped luma ----------------
    logic signed [PW-1:0] r_s1_py, r_s1_cb, r_s1_cr;
    logic [PW-1:0]        r_s1_sat;
    logic [PW-2:0]        r_s1_y0;
    logic [PW-1:0]        abs_cb, abs_cr;

    assign abs_cb = i_pix.in_cb[PW-1] ? PW'(-i_pix.in_cb) : i_pix.in_cb;
    assign abs_cr = i_pix.in_cr[PW-1] ? PW'(-i_pix.in_cr) : i_pix.in_cr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_py  <= i_pix.in_luma;
            r_s1_cb  <= i_pix.in_cb;
            r_s1_cr  <= i_pix.in_cr;
            r_s1_sat <= (abs_cb > abs_cr) ? abs_cb : abs_cr;
            r_s1_y0  <= i_pix.in_luma[PW-1] ? '0 : i_pix.in_luma[PW-2:0];
        end
    end

    // ---------------- stage 2: dividend setup ----------------
    logic signed [PW-1:0] r_s2_py, r_s2_cb, r_s2_cr;
    logic [PW-1:0]        r_s2_sat;
    logic [PW-2:0]        r_s2_y0;
    logic                 r_s2_dark, r_s2_ovf;
    logic [PW+11:0]       r_s2_num_sat;
    logic [2*RW-1:0]      r_s2_num_lum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_py      <= r_s1_py;
            r_s2_cb      <= r_s1_cb;
            r_s2_cr      <= r_s1_cr;
            r_s2_sat     <= r_s1_sat;
            r_s2_y0      <= r_s1_y0;
            r_s2_dark    <= r_s1_y0 < (PW-1)'(r_key_luma);
            r_s2_ovf     <= (PW+1)'(r_s1_sat) >= (PW+1)'({r_keysat, 1'b0});
            r_s2_num_sat <= {r_s1_sat, 12'd0};
            r_s2_num_lum <= r_target_luma * r_s1_y0[RW-1:0];
        end
    end

    // ---------------- angle and quotient units ----------------
    logic [ZW-1:0] ang_pix, ang_key, ang_pix_j, ang_key_j;
    logic [QW-1:0] q_sat, q_lum, q_sat_j, q_lum_j;
    logic [BUS_W-1:0] bus_s2, bus_j;

    ckcr_cordic #(.ITER(ANGLE_BITS)) u_cordic_pix (
        .i_clk(i_clk), .i_en(en),
        .i_x(i_pix.in_cb), .i_y(i_pix.in_cr),
        .o_angle(ang_pix)
    );

    ckcr_cordic #(.ITER(ANGLE_BITS)) u_cordic_key (
        .i_clk(i_clk), .i_en(en),
        .i_x(PW'(r_key_cb)), .i_y(PW'(r_key_cr)),
        .o_angle(ang_key)
    );

    ckcr_div #(.NUM_W(PW+12), .DIV_W(RW), .QW(QW)) u_div_sat (
        .i_clk(i_clk), .i_en(en),
        .i_num(r_s2_num_sat), .i_den(r_keysat), .o_quo(q_sat)
    );

    ckcr_div #(.NUM_W(2*RW), .DIV_W(RW), .QW(QW)) u_div_lum (
        .i_clk(i_clk), .i_en(en),
        .i_num(r_s2_num_lum), .i_den(r_key_luma), .o_quo(q_lum)
    );

    // align all branches at the join stage
    ckcr_delay #(.W(2*ZW), .LEN(JOIN-LAT_COR)) u_dly_ang (
        .i_clk(i_clk), .i_en(en),
        .i_d({ang_pix, ang_key}), .o_d({ang_pix_j, ang_key_j})
    );

    ckcr_delay #(.W(2*QW), .LEN(JOIN-LAT_DIV)) u_dly_quo (
        .i_clk(i_clk), .i_en(en),
        .i_d({q_sat, q_lum}), .o_d({q_sat_j, q_lum_j})
    );

    assign bus_s2 = {r_s2_py, r_s2_cb, r_s2_cr, r_s2_sat, r_s2_y0, r_s2_dark, r_s2_ovf};

    ckcr_delay #(.W(BUS_W), .LEN(JOIN-2)) u_dly_pix (
        .i_clk(i_clk), .i_en(en), .i_d(bus_s2), .o_d(bus_j)
    );

    logic signed [PW-1:0] j_py, j_cb, j_cr;
    logic [PW-1:0]        j_sat;
    logic [PW-2:0]        j_y0;
    logic                 j_dark, j_ovf;

    assign {j_py, j_cb, j_cr, j_sat, j_y0, j_dark, j_ovf} = bus_j;

    // ---------------- stage J+1: hue and saturation excess ----------------
    logic [ZW-1:0] ang_diff;
    logic [PW-1:0] hue_u, hue_d, hue_win, sat_d;
    logic [PW-1:0] r_h_sub_hue, r_h_sub_sat;
    logic [QW:0]   r_h_qs;
    logic [RW-1:0] r_h_ty;
    logic signed [PW-1:0] r_h_py, r_h_cb, r_h_cr;
    logic [PW-2:0] r_h_y0;

    always_comb begin
        ang_diff  = ang_pix_j - ang_key_j;
        hue_u     = PW'((ang_diff + 32'h0000_8000) >> 16);
        hue_d     = hue_u[PW-1] ? PW'(-hue_u) : hue_u;
        hue_win   = {r_hue_tol, 7'd0};
        sat_d     = (j_sat >= PW'(r_keysat)) ? (j_sat - PW'(r_keysat))
                                             : (PW'(r_keysat) - j_sat);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_sub_hue <= (hue_d > hue_win) ? (hue_d - hue_win) : '0;
            r_h_sub_sat <= (sat_d > PW'(r_sat_range)) ? (sat_d - PW'(r_sat_range)) : '0;
            r_h_qs      <= j_ovf ? {1'b1, {QW{1'b0}}} : {1'b0, q_sat_j};
            r_h_ty      <= j_dark ? q_lum_j : r_target_luma;
            r_h_py      <= j_py;
            r_h_cb      <= j_cb;
            r_h_cr      <= j_cr;
            r_h_y0      <= j_y0;
        end
    end

    // ---------------- stage J+2: weight, differences ----------------
    logic [PW+2:0]        penalty;
    logic [RW-1:0]        w_val;
    logic                 r_w_pos;
    logic [RW-1:0]        r_w_w, r_w_lw;
    logic signed [RW+4:0] r_w_dcb, r_w_dcr;
    logic signed [PW-1:0] r_w_dy;
    logic signed [PW-1:0] r_w_py, r_w_cb, r_w_cr;
    logic [PW-2:0]        r_w_y0;

    always_comb begin
        penalty = (PW+3)'(r_h_sub_hue) + {r_h_sub_sat, 3'b000};
        w_val   = RW'((PW+3)'(ckcr_pkg::WEIGHT_ONE) - penalty);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w_pos <= penalty < (PW+3)'(ckcr_pkg::WEIGHT_ONE);
            r_w_w   <= w_val;
            r_w_lw  <= ({1'b0, w_val} <= r_h_qs) ? w_val : r_h_qs[RW-1:0];
            r_w_dcb <= (RW+5)'(r_target_cb) - (RW+5)'(r_h_cb);
            r_w_dcr <= (RW+5)'(r_target_cr) - (RW+5)'(r_h_cr);
            r_w_dy  <= signed'(PW'(r_h_ty)) - signed'(PW'(r_h_y0));
            r_w_py  <= r_h_py;
            r_w_cb  <= r_h_cb;
            r_w_cr  <= r_h_cr;
            r_w_y0  <= r_h_y0;
        end
    end

    // ---------------- stage J+3: blend products ----------------
    logic signed [RW:0]     w_s, lw_s;
    logic signed [2*RW+5:0] r_m_cb, r_m_cr;
    logic signed [PW+RW:0]  r_m_y;
    logic                   r_m_pos;
    logic signed [PW-1:0]   r_m_py, r_m_cb_in, r_m_cr_in;
    logic [PW-2:0]          r_m_y0;

    assign w_s  = signed'({1'b0, r_w_w});
    assign lw_s = signed'({1'b0, r_w_lw});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_cb    <= r_w_dcb * w_s;
            r_m_cr    <= r_w_dcr * w_s;
            r_m_y     <= r_w_dy * lw_s;
            r_m_pos   <= r_w_pos;
            r_m_py    <= r_w_py;
            r_m_cb_in <= r_w_cb;
            r_m_cr_in <= r_w_cr;
            r_m_y0    <= r_w_y0;
        end
    end

    // ---------------- output register ----------------
    logic signed [PW-1:0] r_o_luma, r_o_cb, r_o_cr;

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_m_pos) begin
                r_o_cb   <= r_m_cb_in + PW'(r_m_cb >>> 12);
                r_o_cr   <= r_m_cr_in + PW'(r_m_cr >>> 12);
                r_o_luma <= signed'({1'b0, r_m_y0}) + PW'(r_m_y >>> 12);
            end else begin
                r_o_cb   <= r_m_cb_in;
                r_o_cr   <= r_m_cr_in;
                r_o_luma <= r_m_py;
            end
        end
    end

    assign o_pix.out_luma = r_o_luma;
    assign o_pix.out_cb   = r_o_cb;
    assign o_pix.out_cr   = r_o_cr;

`ifndef SYNTHESIS
    // backpressure: a full tail with a stalled output must hold off input
    a_tail_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAST] && r_vld[LAST-1] && !o_pix.ready) |-> !i_pix.ready)
        else $error("input taken while pipeline tail is blocked");

    // an accepted item shows up in the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_vld[1])
        else $error("accepted item not captured in stage 1");

    // key saturation is the divisor of the saturation quotient and never zero
    a_keysat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_keysat != '0)
        else $error("key saturation is zero");
`endif
endmodule
